[rtl/crcfd_pkg.sv]
// Shared types, constants and the CRC8 step function of the frame deframer.
package crcfd_pkg;

   localparam int unsigned BYTE_WIDTH           = 8;
   localparam int unsigned LENGTH_WIDTH         = 7;
   localparam int unsigned INDEX_WIDTH          = 6;
   localparam int unsigned CSR_INDEX_WIDTH      = 3;
   localparam int unsigned CSR_DATA_WIDTH       = 8;
   localparam int unsigned MAX_FRAME_LENGTH_DEF = 64;
   localparam int unsigned MIN_FRAME_LENGTH     = 3;

   localparam logic [BYTE_WIDTH-1:0]   HEADER1_RESET    = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0]   HEADER2_RESET    = 8'h55;
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RESET = 7'd64;
   localparam logic [BYTE_WIDTH-1:0]   CRC_SEED_RESET   = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0]   CRC_POLY_RESET   = 8'h8C;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HEADER_FIRST   = 3'd0,
      CSR_HEADER_SECOND  = 3'd1,
      CSR_MAX_LENGTH     = 3'd2,
      CSR_CRC_SEED       = 3'd3,
      CSR_CRC_POLYNOMIAL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic len_load;
      logic type_load;
      logic pay_load;
      logic emit_start;
      logic rd_issue;
   } cmd_type;

   typedef struct packed {
      logic hdr1_hit;
      logic hdr2_hit;
      logic len_ok;
      logic pay_done;
      logic crc_hit;
      logic rd_last;
      logic rd_busy;
      logic out_free;
   } status_type;

   function automatic logic [BYTE_WIDTH-1:0] crc8_feed(
      input logic [BYTE_WIDTH-1:0] crc,
      input logic [BYTE_WIDTH-1:0] data,
      input logic [BYTE_WIDTH-1:0] poly
   );
      logic [BYTE_WIDTH-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/crcfd_if.sv]
// Handshake interfaces for the byte request, result and register write channels.
interface crcfd_req_if import crcfd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfd_rsp_if import crcfd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BYTE_WIDTH-1:0]  frame_type;
   logic [INDEX_WIDTH-1:0] payload_index;
   logic [BYTE_WIDTH-1:0]  payload_byte;
   logic                   last_byte;

   modport source (output valid, output frame_type, output payload_index,
                   output payload_byte, output last_byte, input ready);
   modport sink (input valid, input frame_type, input payload_index,
                 input payload_byte, input last_byte, output ready);
endinterface

interface crcfd_csr_if import crcfd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/crcfd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module crcfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 62
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/crcfd_ctrl.sv]
// Frame parsing and payload readout state machine.
module crcfd_ctrl import crcfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_HDR1,
      ST_HDR2,
      ST_TYPE,
      ST_PAYLOAD,
      ST_CRC,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff != ST_EMIT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.hdr1_hit) begin
               state_in = ST_HDR1;
            end
         end
         ST_HDR1: begin
            if (accept) begin
               state_in = status.hdr2_hit ? ST_HDR2 : ST_HUNT;
            end
         end
         ST_HDR2: begin
            if (accept) begin
               if (status.len_ok) begin
                  cmd.len_load = 1'b1;
                  state_in     = ST_TYPE;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_TYPE: begin
            if (accept) begin
               cmd.type_load = 1'b1;
               state_in      = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               cmd.pay_load = 1'b1;
               if (status.pay_done) begin
                  state_in = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            if (accept) begin
               if (status.crc_hit) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (!status.rd_busy && status.out_free) begin
               cmd.rd_issue = 1'b1;
               if (status.rd_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/crcfd_datapath.sv]
// Configuration registers, CRC8, frame counters, payload store and result register.
module crcfd_datapath import crcfd_pkg::*; #(
   parameter int unsigned MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic [BYTE_WIDTH-1:0]      req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BYTE_WIDTH-1:0]      rsp_frame_type,
   output logic [INDEX_WIDTH-1:0]     rsp_payload_index,
   output logic [BYTE_WIDTH-1:0]      rsp_payload_byte,
   output logic                       rsp_last_byte,
   input  cmd_type                    cmd,
   output status_type                 status
);

   localparam int unsigned STORE_DEPTH = MAX_FRAME_LENGTH - 2;
   localparam int unsigned ADDR_WIDTH  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [BYTE_WIDTH-1:0]   LENGTH_CAP = BYTE_WIDTH'(MAX_FRAME_LENGTH);
   localparam logic [LENGTH_WIDTH-1:0] DEPTH_LIM  = LENGTH_WIDTH'(STORE_DEPTH);

   logic [BYTE_WIDTH-1:0]   hdr1_ff, hdr1_in;
   logic [BYTE_WIDTH-1:0]   hdr2_ff, hdr2_in;
   logic [LENGTH_WIDTH-1:0] maxlen_ff, maxlen_in;
   logic [BYTE_WIDTH-1:0]   seed_ff, seed_in;
   logic [BYTE_WIDTH-1:0]   poly_ff, poly_in;
   logic [LENGTH_WIDTH-1:0] frame_length_ff, frame_length_in;
   logic [LENGTH_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_WIDTH-1:0]   held_type_ff, held_type_in;
   logic [BYTE_WIDTH-1:0]   crc_ff, crc_in;
   logic [INDEX_WIDTH-1:0]  rd_idx_ff, rd_idx_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [INDEX_WIDTH-1:0]  rd_tag_ff, rd_tag_in;
   logic                    rd_last_ff, rd_last_in;
   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_WIDTH-1:0]   out_type_ff, out_type_in;
   logic [INDEX_WIDTH-1:0]  out_index_ff, out_index_in;
   logic [BYTE_WIDTH-1:0]   out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;

   logic [BYTE_WIDTH-1:0]   limit;
   logic [BYTE_WIDTH-1:0]   crc_base;
   logic [BYTE_WIDTH-1:0]   crc_next;
   logic                    ram_wr_en;
   logic [BYTE_WIDTH-1:0]   ram_rd_data;
   logic                    rd_last_now;

   assign csr_ready = 1'b1;

   assign limit    = ({1'b0, maxlen_ff} > LENGTH_CAP) ? LENGTH_CAP : {1'b0, maxlen_ff};
   assign crc_base = cmd.len_load ? seed_ff : crc_ff;
   assign crc_next = crc8_feed(crc_base, req_rx_byte, poly_ff);

   assign rd_last_now = (({1'b0, rd_idx_ff}) + LENGTH_WIDTH'(1)) == byte_count_ff;
   assign ram_wr_en   = cmd.pay_load && (byte_count_ff < DEPTH_LIM);

   assign status.hdr1_hit = (req_rx_byte == hdr1_ff);
   assign status.hdr2_hit = (req_rx_byte == hdr2_ff);
   assign status.len_ok   = (req_rx_byte >= BYTE_WIDTH'(MIN_FRAME_LENGTH))
                            && (req_rx_byte <= limit);
   assign status.pay_done = ({1'b0, byte_count_ff} + BYTE_WIDTH'(MIN_FRAME_LENGTH))
                            >= {1'b0, frame_length_ff};
   assign status.crc_hit  = (crc_ff == req_rx_byte);
   assign status.rd_last  = rd_last_now;
   assign status.rd_busy  = rd_valid_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      hdr1_in   = hdr1_ff;
      hdr2_in   = hdr2_ff;
      maxlen_in = maxlen_ff;
      seed_in   = seed_ff;
      poly_in   = poly_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:   hdr1_in   = csr_data;
            CSR_HEADER_SECOND:  hdr2_in   = csr_data;
            CSR_MAX_LENGTH:     maxlen_in = csr_data[LENGTH_WIDTH-1:0];
            CSR_CRC_SEED:       seed_in   = csr_data;
            CSR_CRC_POLYNOMIAL: poly_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      frame_length_in = frame_length_ff;
      byte_count_in   = byte_count_ff;
      held_type_in    = held_type_ff;
      crc_in          = crc_ff;
      if (cmd.len_load) begin
         frame_length_in = req_rx_byte[LENGTH_WIDTH-1:0];
         byte_count_in   = '0;
         crc_in          = crc_next;
      end
      if (cmd.type_load) begin
         held_type_in  = req_rx_byte;
         byte_count_in = '0;
         crc_in        = crc_next;
      end
      if (cmd.pay_load) begin
         byte_count_in = byte_count_ff + LENGTH_WIDTH'(1);
         crc_in        = crc_next;
      end
   end

   always_comb begin
      rd_idx_in    = rd_idx_ff;
      rd_valid_in  = cmd.rd_issue;
      rd_tag_in    = rd_tag_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_type_in  = out_type_ff;
      out_index_in = out_index_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_start) begin
         rd_idx_in = '0;
      end
      if (cmd.rd_issue) begin
         rd_idx_in  = rd_idx_ff + INDEX_WIDTH'(1);
         rd_tag_in  = rd_idx_ff;
         rd_last_in = rd_last_now;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (rd_valid_ff) begin
         out_valid_in = 1'b1;
         out_type_in  = held_type_ff;
         out_index_in = rd_tag_ff;
         out_byte_in  = ram_rd_data;
         out_last_in  = rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr1_ff         <= HEADER1_RESET;
         hdr2_ff         <= HEADER2_RESET;
         maxlen_ff       <= MAX_LENGTH_RESET;
         seed_ff         <= CRC_SEED_RESET;
         poly_ff         <= CRC_POLY_RESET;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         held_type_ff    <= '0;
         crc_ff          <= CRC_SEED_RESET;
         rd_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         hdr1_ff         <= hdr1_in;
         hdr2_ff         <= hdr2_in;
         maxlen_ff       <= maxlen_in;
         seed_ff         <= seed_in;
         poly_ff         <= poly_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         held_type_ff    <= held_type_in;
         crc_ff          <= crc_in;
         rd_valid_ff     <= rd_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      rd_tag_ff    <= rd_tag_in;
      rd_last_ff   <= rd_last_in;
      out_type_ff  <= out_type_in;
      out_index_ff <= out_index_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   crcfd_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (byte_count_ff[ADDR_WIDTH-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff[ADDR_WIDTH-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_type    = out_type_ff;
   assign rsp_payload_index = out_index_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_last_byte     = out_last_ff;

endmodule

[rtl/crc8_frame_deframer_unit.sv]
// Top level of the CRC8 frame deframer: byte request in, payload results out.
// The block takes one received byte per request and accepts a request in every cycle
// while it hunts for the two header bytes and while it collects the length, type,
// payload and CRC bytes. The request that carries a matching CRC byte causes L-2
// results, one per payload byte, tagged with the frame type and marked last at the
// end; during that run the request channel is held off. Each result passes through
// the registered read port of the payload store and then the result register; the
// next read is issued only once the previous one has left the read port and the
// result register is free, so result channel stalls lengthen the run. The payload
// store is not cleared after reset and needs no clearing pass. Registers are written
// through the csr channel, which is always ready, and should only be written while
// the block is idle.
module crc8_frame_deframer_unit import crcfd_pkg::*; #(
   parameter int unsigned MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   crcfd_req_if.sink  req,
   crcfd_rsp_if.source rsp,
   crcfd_csr_if.sink  csr
);

   cmd_type    cmd;
   status_type status;

   crcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   crcfd_datapath #(
      .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr.valid),
      .csr_ready         (csr.ready),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .req_rx_byte       (req.rx_byte),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_frame_type    (rsp.frame_type),
      .rsp_payload_index (rsp.payload_index),
      .rsp_payload_byte  (rsp.payload_byte),
      .rsp_last_byte     (rsp.last_byte),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

[rtl/crcfd_checker.sv]
// Port-level assertions for the frame deframer and their bind to the top level.
module crcfd_checker import crcfd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [BYTE_WIDTH-1:0]  rsp_frame_type,
   input logic [INDEX_WIDTH-1:0] rsp_payload_index,
   input logic [BYTE_WIDTH-1:0]  rsp_payload_byte,
   input logic                   rsp_last_byte
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_type)
         && $stable(rsp_payload_index) && $stable(rsp_payload_byte)
         && $stable(rsp_last_byte))
      else $error("stalled result changed");

   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> !req_ready)
      else $error("request taken while a payload run is still open");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=> !rsp_valid ##1 (rsp_valid
         && rsp_payload_index == $past(rsp_payload_index, 2) + INDEX_WIDTH'(1)
         && rsp_frame_type == $past(rsp_frame_type, 2)))
      else $error("payload run broke its index sequence");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind crc8_frame_deframer_unit crcfd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_frame_type    (rsp.frame_type),
   .rsp_payload_index (rsp.payload_index),
   .rsp_payload_byte  (rsp.payload_byte),
   .rsp_last_byte     (rsp.last_byte)
);
